// ===== hw/rtl/pcmf_pkg.sv =====
`default_nettype none
package pcmf_pkg;

	typedef enum logic [1:0] {
		MODE_ENC_L16 = 2'd0,
		MODE_DEC_L16 = 2'd1,
		MODE_ENC_L24 = 2'd2,
		MODE_DEC_L24 = 2'd3
	} mode_t;

	localparam logic [23:0] ENC_L16_SCALE = 24'd32767;
	localparam logic [23:0] ENC_L24_SCALE = 24'd8388607;
	localparam logic [23:0] L16_MASK      = 24'h00FFFF;

	typedef struct packed {
		logic [31:0] float_bits;
		logic [23:0] payload;
		logic        last;
	} result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pcmf_encode.sv =====
`default_nettype none
module pcmf_encode import pcmf_pkg::*; (
	input  wire logic [31:0] float_in,
	input  wire logic        is_l24,
	output logic      [23:0] code
);
	// Clamped |x| <= 1 times a 24-bit scale, rounded to single precision (RNE),
	// then truncated toward zero.
	logic        sgn;
	logic [7:0]  expo;
	logic [22:0] frac;
	logic        is_nan;
	logic        clamp_one;
	logic [23:0] mant;
	logic [23:0] scale;
	logic [47:0] prod;
	logic [5:0]  msb;
	logic [5:0]  lz;
	logic [47:0] norm;
	logic [23:0] m24;
	logic        rbit;
	logic        sticky;
	logic [24:0] mr;
	logic [7:0]  e2;
	logic [24:0] val;
	logic [8:0]  shamt;
	logic [23:0] mag;
	logic        neg;

	always_comb begin
		sgn    = float_in[31];
		expo   = float_in[30:23];
		frac   = float_in[22:0];
		is_nan = (expo == 8'hFF) && (frac != 23'd0);
		clamp_one = is_nan || (expo >= 8'd127);
		neg    = sgn && !is_nan;
		mant   = (expo == 8'd0) ? {1'b0, frac} : {1'b1, frac};
		scale  = is_l24 ? ENC_L24_SCALE : ENC_L16_SCALE;
		prod   = mant * scale;
		msb    = 6'd0;
		for (int i = 0; i < 48; i++) begin
			if (prod[i]) begin
				msb = 6'(i);
			end
		end
		lz     = 6'd47 - msb;
		norm   = prod << lz;
		m24    = norm[47:24];
		rbit   = norm[23];
		sticky = |norm[22:0];
		mr = {1'b0, m24} + {24'd0, rbit && (sticky || m24[0])};
		// The rounded product is mr * 2^(e2 + 24 - lz - 150).
		e2 = (expo == 8'd0) ? 8'd1 : expo;
		shamt = 9'd126 - {1'b0, e2} + {3'd0, lz};
		val = 25'd0;
		if (clamp_one) begin
			mag = scale;
		end else if (shamt > 9'd24) begin
			mag = 24'd0;
		end else begin
			val = mr >> shamt[4:0];
			mag = val[23:0];
		end
		code = neg ? (24'd0 - mag) : mag;
		if (!is_l24) begin
			code = code & L16_MASK;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/pcmf_decode.sv =====
`default_nettype none
module pcmf_decode import pcmf_pkg::*; (
	input  wire logic [23:0] payload_in,
	input  wire logic        is_l24,
	output logic      [31:0] float_bits
);
	logic [23:0] raw;
	logic        sgn;
	logic [23:0] mag;
	logic [4:0]  lead;
	logic [23:0] norm;
	logic [7:0]  expo;

	always_comb begin
		raw = is_l24 ? payload_in : {{8{payload_in[15]}}, payload_in[15:0]};
		sgn = raw[23];
		mag = sgn ? (24'd0 - raw) : raw;
		lead = 5'd0;
		for (int i = 0; i < 24; i++) begin
			if (mag[i]) begin
				lead = 5'(i);
			end
		end
		norm = mag << (5'd23 - lead);
		// The sample is divided by 2^23 for L24 and by 2^15 for L16.
		expo = 8'd127 - (is_l24 ? 8'd23 : 8'd15) + {3'd0, lead};
		if (mag == 24'd0) begin
			float_bits = 32'd0;
		end else begin
			float_bits = {sgn, expo, norm[22:0]};
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/pcm_float_sample_converter.sv =====
// Channel | Direction | Handshake   | Fields
// in      | input     | valid/ready | mode, float_in, payload_in, last_in
// out     | output    | valid/ready | float_out, payload_out, last_out
// One beat per clock while the output is not stalled: an input register feeds
// the conversion logic and the result register.
// Both stages advance whenever the stage ahead is empty or being emptied.
// A stall on the output holds the result stage, and the input stage when it is full; in_ready follows the input stage.
// Reset clears the valid bits of both stages.
`default_nettype none
module pcm_float_sample_converter import pcmf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [31:0] float_in,
	input  wire logic [23:0] payload_in,
	input  wire logic        last_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [31:0] float_out,
	output logic      [23:0] payload_out,
	output logic             last_out
);
	logic        v_s1;
	logic [1:0]  mode_s1;
	logic [31:0] float_s1;
	logic [23:0] pay_s1;
	logic        last_s1;
	logic        v_s2;
	result_t     res_s2;
	result_t     res;
	logic [23:0] enc;
	logic [31:0] dec;
	logic        adv2;
	logic        adv1;

	pcmf_encode u_enc (.float_in(float_s1), .is_l24(mode_s1[1]), .code(enc));
	pcmf_decode u_dec (.payload_in(pay_s1), .is_l24(mode_s1[1]), .float_bits(dec));

	always_comb begin
		res.last = last_s1;
		case (mode_t'(mode_s1))
			MODE_ENC_L16, MODE_ENC_L24: begin
				res.float_bits = 32'd0;
				res.payload    = enc;
			end
			default: begin
				res.float_bits = dec;
				res.payload    = 24'd0;
			end
		endcase
	end

	assign adv2     = !v_s2 || out_ready;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			mode_s1  <= mode;
			float_s1 <= float_in;
			pay_s1   <= payload_in;
			last_s1  <= last_in;
		end
		if (adv2 && v_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = v_s2;
	assign float_out   = res_s2.float_bits;
	assign payload_out = res_s2.payload;
	assign last_out    = res_s2.last;
endmodule
`default_nettype wire

// ===== hw/rtl/pcmf_checker.sv =====
`default_nettype none
module pcmf_checker import pcmf_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] float_out,
	input wire logic [23:0] payload_out
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_out) && $stable(float_out))
		else $error("Output beat changed while stalled.");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (float_out == 32'd0) || (payload_out == 24'd0))
		else $error("Both result fields nonzero.");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("Input stalled with empty output.");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 1'b1 |=> out_valid)
		else $error("Accepted beat did not reach output.");
endmodule

bind pcm_float_sample_converter pcmf_checker u_chk (.*);
`default_nettype wire

// ===== tb/pcm_float_sample_converter_test.sv =====
`timescale 1ns / 100ps
module pcm_float_sample_converter_test;
	import pcmf_pkg::*;

	typedef struct {
		logic [31:0] float_bits;
		logic [23:0] payload;
		logic        last;
	} sample_t;

	typedef struct {
		mode_t       mode;
		logic [31:0] float_in;
		logic [23:0] payload_in;
		logic        last_in;
		bit          typed;
		logic [31:0] float_exp;
		logic [23:0] payload_exp;
	} row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [1:0]  mode = MODE_ENC_L16;
	logic [31:0] float_in = '0;
	logic [23:0] payload_in = '0;
	logic        last_in = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [31:0] float_out;
	logic [23:0] payload_out;
	logic        last_out;

	bit          typed_row = 0;
	logic [31:0] typed_float = '0;
	logic [23:0] typed_payload = '0;

	sample_t     pending_q[$];
	int          failures = 0;
	int          idle_cycles = 0;
	int          send_gap_pct = 0;
	int          recv_stall_pct = 0;

	always #5 clk = ~clk;

	pcm_float_sample_converter uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .float_in(float_in), .payload_in(payload_in), .last_in(last_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.float_out(float_out), .payload_out(payload_out), .last_out(last_out)
	);

	// Clamp, scale with single-precision rounding to nearest even, truncate toward zero.
	function automatic logic [23:0] encode_code(logic [31:0] f, logic [23:0] scale,
			logic [23:0] mask);
		logic [7:0]  ex;
		logic [63:0] prod;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		logic [63:0] mag;
		int          msb;
		int          sh;
		int          t;
		ex = f[30:23];
		mag = 0;
		if (ex == 8'hFF && f[22:0] != 0) begin
			return scale & mask;
		end else if (ex >= 8'd127) begin
			mag = {40'd0, scale};
		end else if (ex != 0) begin
			prod = {40'd0, 1'b1, f[22:0]} * {40'd0, scale};
			msb = 0;
			for (int i = 0; i < 64; i++)
				if (prod[i])
					msb = i;
			sh = (msb > 23) ? msb - 23 : 0;
			q = prod >> sh;
			if (sh > 0) begin
				rem = prod & ((64'd1 << sh) - 1);
				half = 64'd1 << (sh - 1);
				if (rem > half || (rem == half && q[0]))
					q = q + 1;
			end
			t = sh + int'(ex) - 150;
			if (t >= 0)
				mag = q << t;
			else if (-t < 64)
				mag = q >> (-t);
		end
		if (f[31])
			mag = -mag;
		return mag[23:0] & mask;
	endfunction

	// Sign-extend and divide by a power of two, which only moves the exponent.
	function automatic logic [31:0] decode_value(logic [23:0] raw, int bits);
		logic [23:0] mag;
		logic        neg;
		logic [23:0] norm;
		int          msb;
		neg = raw[bits-1];
		mag = neg ? ((24'd1 << bits) - raw) : raw;
		mag = mag & ((24'd1 << bits) - 1) | (neg && mag == 0 ? 24'd1 << (bits - 1) : 24'd0);
		if (neg && raw == (24'd1 << (bits - 1)))
			mag = 24'd1 << (bits - 1);
		if (mag == 0)
			return 32'd0;
		msb = 0;
		for (int i = 0; i < 24; i++)
			if (mag[i])
				msb = i;
		norm = mag << (23 - msb);
		return {neg, 8'(127 + msb - (bits - 1)), norm[22:0]};
	endfunction

	function automatic sample_t convert_sample(logic [1:0] m, logic [31:0] f,
			logic [23:0] p, logic l);
		sample_t r;
		r.float_bits = '0;
		r.payload = '0;
		r.last = l;
		case (mode_t'(m))
			MODE_ENC_L16: r.payload = encode_code(f, ENC_L16_SCALE, L16_MASK);
			MODE_DEC_L16: r.float_bits = decode_value(p & L16_MASK, 16);
			MODE_ENC_L24: r.payload = encode_code(f, ENC_L24_SCALE, 24'hFFFFFF);
			default:      r.float_bits = decode_value(p, 24);
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		sample_t want;
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= 5000) begin
			$display("Test completed with failures");
			$finish;
		end
		if (in_valid && in_ready) begin
			want = convert_sample(mode, float_in, payload_in, last_in);
			if (typed_row) begin
				want.float_bits = typed_float;
				want.payload = typed_payload;
			end
			pending_q.push_back(want);
		end
		if (out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$error("unexpected beat: float_out %h payload_out %h", float_out, payload_out);
				failures++;
			end else begin
				want = pending_q.pop_front();
				if (float_out !== want.float_bits) begin
					$error("float_out expected %h actual %h", want.float_bits, float_out);
					failures++;
				end
				if (payload_out !== want.payload) begin
					$error("payload_out expected %h actual %h", want.payload, payload_out);
					failures++;
				end
				if (last_out !== want.last) begin
					$error("last_out expected %b actual %b", want.last, last_out);
					failures++;
				end
			end
		end
	end

	task automatic send_beat(logic [1:0] m, logic [31:0] f, logic [23:0] p, logic l,
			bit typed, logic [31:0] tf, logic [23:0] tp);
		if ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < send_gap_pct)
				@(posedge clk);
		end
		in_valid <= 1;
		mode <= m;
		float_in <= f;
		payload_in <= p;
		last_in <= l;
		typed_row <= typed;
		typed_float <= tf;
		typed_payload <= tp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	function automatic logic [31:0] random_float();
		int pick;
		pick = $urandom_range(99);
		if (pick < 55)
			return {1'($urandom), 8'($urandom_range(127, 100)), 23'($urandom)};
		else if (pick < 65)
			return {1'($urandom), 8'($urandom_range(126, 0)), 23'($urandom)};
		else if (pick < 75)
			return {1'($urandom), 8'hFF, ($urandom_range(1) ? 23'($urandom) : 23'd0)};
		else
			return $urandom;
	endfunction

	row_t directed[] = '{
		'{MODE_ENC_L16, 32'h3F800000, 24'h0, 1'b0, 1, 32'h0, 24'h007FFF},
		'{MODE_ENC_L16, 32'hBF800000, 24'hFFFFFF, 1'b1, 1, 32'h0, 24'h008001},
		'{MODE_ENC_L16, 32'h7FC00000, 24'h0, 1'b0, 1, 32'h0, 24'h007FFF},
		'{MODE_ENC_L16, 32'hFFFFFFFF, 24'h0, 1'b0, 1, 32'h0, 24'h007FFF},
		'{MODE_ENC_L16, 32'h7F800000, 24'h0, 1'b0, 1, 32'h0, 24'h007FFF},
		'{MODE_ENC_L16, 32'hFF800000, 24'h0, 1'b1, 1, 32'h0, 24'h008001},
		'{MODE_ENC_L16, 32'h80000000, 24'h0, 1'b0, 1, 32'h0, 24'h000000},
		'{MODE_ENC_L16, 32'h40000000, 24'h0, 1'b0, 1, 32'h0, 24'h007FFF},
		'{MODE_ENC_L16, 32'h3F000000, 24'h0, 1'b0, 1, 32'h0, 24'h003FFF},
		'{MODE_ENC_L16, 32'h3F7FFFFF, 24'h0, 1'b0, 0, 32'h0, 24'h0},
		'{MODE_ENC_L16, 32'h00000001, 24'h0, 1'b0, 0, 32'h0, 24'h0},
		'{MODE_ENC_L24, 32'h3F800000, 24'h0, 1'b0, 1, 32'h0, 24'h7FFFFF},
		'{MODE_ENC_L24, 32'hBF800000, 24'h0, 1'b1, 1, 32'h0, 24'h800001},
		'{MODE_ENC_L24, 32'h7FC00001, 24'h0, 1'b0, 1, 32'h0, 24'h7FFFFF},
		'{MODE_ENC_L24, 32'hFF800000, 24'h0, 1'b0, 1, 32'h0, 24'h800001},
		'{MODE_ENC_L24, 32'hBF7FFFFF, 24'h0, 1'b0, 0, 32'h0, 24'h0},
		'{MODE_DEC_L16, 32'hFFFFFFFF, 24'h008000, 1'b0, 1, 32'hBF800000, 24'h0},
		'{MODE_DEC_L16, 32'h0, 24'h000000, 1'b1, 1, 32'h00000000, 24'h0},
		'{MODE_DEC_L16, 32'h0, 24'hAB0000, 1'b0, 1, 32'h00000000, 24'h0},
		'{MODE_DEC_L16, 32'h0, 24'hFF7FFF, 1'b0, 0, 32'h0, 24'h0},
		'{MODE_DEC_L16, 32'h0, 24'h00FFFF, 1'b0, 0, 32'h0, 24'h0},
		'{MODE_DEC_L24, 32'h0, 24'h800000, 1'b0, 1, 32'hBF800000, 24'h0},
		'{MODE_DEC_L24, 32'h0, 24'h000000, 1'b0, 1, 32'h00000000, 24'h0},
		'{MODE_DEC_L24, 32'h0, 24'h7FFFFF, 1'b1, 0, 32'h0, 24'h0},
		'{MODE_DEC_L24, 32'h0, 24'hFFFFFF, 1'b0, 0, 32'h0, 24'h0}
	};

	initial begin
		int gaps[4];
		int stalls[4];
		gaps = '{0, 80, 0, 15};
		stalls = '{0, 0, 80, 15};
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (directed[i])
			send_beat(directed[i].mode, directed[i].float_in, directed[i].payload_in,
				directed[i].last_in, directed[i].typed, directed[i].float_exp,
				directed[i].payload_exp);
		for (int ph = 0; ph < 4; ph++) begin
			send_gap_pct = gaps[ph];
			recv_stall_pct = stalls[ph];
			if (ph == 2) begin
				in_valid <= 0;
				@(posedge clk);
				while (pending_q.size() != 0)
					@(posedge clk);
			end
			for (int n = 0; n < 500; n++)
				send_beat(2'($urandom), random_float(), 24'($urandom), 1'($urandom),
					0, 32'h0, 24'h0);
		end
		in_valid <= 0;
		recv_stall_pct = 0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
